FILE: rtl/rlmb_pkg.sv
package rlmb_pkg;

  // Slot count and widths of the fixed fields.
  localparam int NUM_CHANNELS = 8;
  localparam int SLOT_W       = 3;
  localparam int FPS_W        = 10;
  localparam int TIME_W       = 32;
  localparam int AGE_W        = 16;

  // Milliseconds per second, the dividend of the interval division.
  localparam logic [FPS_W-1:0] MS_PER_SEC = FPS_W'(1000);

  // Command codes.
  localparam logic [2:0] CMD_REGISTER   = 3'd0;
  localparam logic [2:0] CMD_UNREGISTER = 3'd1;
  localparam logic [2:0] CMD_SUBMIT     = 3'd2;
  localparam logic [2:0] CMD_SELECT     = 3'd3;
  localparam logic [2:0] CMD_COMPLETE   = 3'd4;
  localparam logic [2:0] CMD_START      = 3'd5;
  localparam logic [2:0] CMD_STOP       = 3'd6;

  // Status codes.
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NOT_ACC   = 3'd1;
  localparam logic [2:0] STS_UNKNOWN   = 3'd2;
  localparam logic [2:0] STS_DUPLICATE = 3'd3;
  localparam logic [2:0] STS_NONE      = 3'd4;

  // Configuration register indexes.
  localparam logic REG_MAX_FRAME_AGE = 1'b0;

endpackage

FILE: rtl/rlmb_div.sv
module rlmb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [rlmb_pkg::FPS_W-1:0] divisor,
  output logic                      done,
  output logic [rlmb_pkg::FPS_W-1:0] quotient
);
  import rlmb_pkg::*;

  localparam int CNT_W = $clog2(FPS_W + 1);

  logic [FPS_W-1:0] dvsr;
  logic [FPS_W-1:0] dvnd;
  logic [FPS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [FPS_W:0]   trial;
  logic             fits;

  // One quotient bit per cycle, restoring division of the constant dividend.
  assign trial = {rem, dvnd[FPS_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run      <= 1'b1;
        cnt      <= '0;
        dvsr     <= divisor;
        dvnd     <= MS_PER_SEC;
        rem      <= '0;
        quotient <= '0;
      end else if (run) begin
        dvnd     <= {dvnd[FPS_W-2:0], 1'b0};
        rem      <= fits ? FPS_W'(trial - {1'b0, dvsr}) : trial[FPS_W-1:0];
        quotient <= {quotient[FPS_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(FPS_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/rate_limited_mailbox_round_robin.sv
// Channel     | Direction | Transaction
// command     | in        | start high while busy low; fields sampled at that edge
// result      | out       | done high for one cycle; fields valid in that cycle
// config APB  | in/out    | write at psel & penable & pwrite & pready
//
// Start, stop, unregister and complete are handled in the idle state; submit reads the
// slot memory, then writes it back.
// Register waits on the bit-serial interval divider.
// Select makes one pipelined memory read per slot, plus a close.
// Reset is synchronous; the slot memory needs no clearing pass.
// The result cannot be stalled; busy holds off further commands.
module rate_limited_mailbox_round_robin (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      command,
  input  logic [rlmb_pkg::SLOT_W-1:0]     channel_slot,
  input  logic [rlmb_pkg::FPS_W-1:0]      target_fps,
  input  logic [rlmb_pkg::TIME_W-1:0]     frame_tag,
  input  logic [rlmb_pkg::TIME_W-1:0]     frame_time,
  input  logic [rlmb_pkg::TIME_W-1:0]     now_time,
  output logic                            done,
  output logic [2:0]                      status,
  output logic                            dispatched,
  output logic [rlmb_pkg::SLOT_W-1:0]     out_channel,
  output logic [rlmb_pkg::TIME_W-1:0]     out_frame_tag,
  output logic [rlmb_pkg::TIME_W-1:0]     out_frame_time,
  output logic [rlmb_pkg::TIME_W-1:0]     out_submitted_at,
  output logic                            wake_valid,
  output logic [rlmb_pkg::TIME_W-1:0]     wake_time,
  output logic                            replaced,
  output logic                            throttled,
  output logic [3:0]                      stale_count,
  output logic                            deliver,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rlmb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0] tag;
    logic [TIME_W-1:0] ftime;
    logic [TIME_W-1:0] subm;
    logic [TIME_W-1:0] elig;
    logic [FPS_W-1:0]  intv;
  } entry_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              dispatched;
    logic [SLOT_W-1:0] out_channel;
    logic [TIME_W-1:0] out_frame_tag;
    logic [TIME_W-1:0] out_frame_time;
    logic [TIME_W-1:0] out_submitted_at;
    logic              wake_valid;
    logic [TIME_W-1:0] wake_time;
    logic              replaced;
    logic              throttled;
    logic [3:0]        stale_count;
    logic              deliver;
  } res_t;

  logic [2:0]              state;
  logic [NUM_CHANNELS-1:0] used, regd, running, full;
  logic [SLOT_W-1:0]       rr_pointer;
  logic                    accepting;
  logic [AGE_W-1:0]        max_frame_age;

  logic [SLOT_W-1:0]       slot_q, ptr_q, ev_slot;
  logic [TIME_W-1:0]       tag_q, ftime_q, now_q, cutoff_q;
  logic                    age_en_q;
  logic [3:0]              scan_cnt;
  logic [3:0]              drops;
  logic                    wv, done_sel;
  logic [TIME_W-1:0]       wake;
  logic [SLOT_W-1:0]       sel_ch;
  logic [TIME_W-1:0]       sel_tag, sel_time, sel_sub;

  entry_t                  mem [NUM_CHANNELS];
  entry_t                  rd_data, wr_data;
  logic [SLOT_W-1:0]       rd_addr, wr_addr;
  logic                    wr_en;

  logic                    accept, in_range;
  logic                    div_go, div_done;
  logic [FPS_W-1:0]        div_q, divisor;
  logic                    stale_now, cand_now, early_now, disp_now;
  logic [TIME_W:0]         elig_sum;
  logic [TIME_W-1:0]       elig_sat;
  res_t                    res, res_next;
  logic                    fire;

  assign busy     = state != ST_IDLE;
  assign accept   = start && !busy;
  assign in_range = 32'(channel_slot) < NUM_CHANNELS;
  assign divisor  = (target_fps == '0) ? FPS_W'(1) : target_fps;
  assign div_go   = accept && command == CMD_REGISTER && in_range && !used[channel_slot];

  rlmb_div u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .divisor (divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {16'd0, max_frame_age} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_age <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_FRAME_AGE
                 && paddr[1:0] == 2'd0) begin
      max_frame_age <= pwdata[AGE_W-1:0];
    end
  end

  // Slot evaluation during a select scan.
  always_comb begin
    stale_now = age_en_q && used[ev_slot] && full[ev_slot] && rd_data.ftime != '0
                && rd_data.ftime < cutoff_q;
    cand_now  = used[ev_slot] && regd[ev_slot] && full[ev_slot] && !stale_now
                && !running[ev_slot] && !done_sel;
    early_now = now_q < rd_data.elig;
    disp_now  = state == ST_SCAN && cand_now && !early_now;
    elig_sum  = {1'b0, now_q} + (TIME_W + 1)'(rd_data.intv);
    elig_sat  = elig_sum[TIME_W] ? '1 : elig_sum[TIME_W-1:0];
  end

  // Memory addressing and write-back.
  always_comb begin
    rd_addr = slot_q;
    if (state == ST_IDLE) begin
      rd_addr = (command == CMD_SELECT) ? rr_pointer : channel_slot;
    end else if (state == ST_SCAN) begin
      rd_addr = ptr_q + scan_cnt[SLOT_W-1:0];
    end
    wr_en   = 1'b0;
    wr_addr = slot_q;
    wr_data = rd_data;
    case (state)
      ST_DIV: begin
        wr_en   = div_done;
        wr_data = '{tag: '0, ftime: '0, subm: '0, elig: '0, intv: div_q};
      end
      ST_SUB: begin
        wr_en         = 1'b1;
        wr_data.tag   = tag_q;
        wr_data.ftime = ftime_q;
        wr_data.subm  = now_q;
      end
      ST_SCAN: begin
        wr_en        = disp_now;
        wr_addr      = ev_slot;
        wr_data.elig = elig_sat;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Result of the current transaction.
  always_comb begin
    res_next = '0;
    fire     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_REGISTER: begin
              if (!in_range) begin
                fire            = 1'b1;
                res_next.status = STS_UNKNOWN;
              end else if (used[channel_slot]) begin
                fire            = 1'b1;
                res_next.status = STS_DUPLICATE;
              end
            end
            CMD_UNREGISTER: begin
              fire = 1'b1;
              if (!in_range || !used[channel_slot]) res_next.status = STS_UNKNOWN;
            end
            CMD_SUBMIT: begin
              if (!accepting) begin
                fire            = 1'b1;
                res_next.status = STS_NOT_ACC;
              end else if (!in_range || !used[channel_slot] || !regd[channel_slot]) begin
                fire            = 1'b1;
                res_next.status = STS_UNKNOWN;
              end
            end
            CMD_SELECT: begin
              if (!accepting) begin
                fire            = 1'b1;
                res_next.status = STS_NOT_ACC;
              end
            end
            CMD_COMPLETE: begin
              fire = 1'b1;
              if (!in_range || !used[channel_slot]) begin
                res_next.status = STS_UNKNOWN;
              end else if (running[channel_slot]) begin
                res_next.deliver = accepting && regd[channel_slot];
              end
            end
            default: begin
              fire = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        fire = div_done;
      end
      ST_SUB: begin
        fire               = 1'b1;
        res_next.replaced  = full[slot_q];
        res_next.throttled = running[slot_q] || now_q < rd_data.elig;
      end
      ST_FIN: begin
        fire                      = 1'b1;
        res_next.status           = done_sel ? STS_OK : STS_NONE;
        res_next.dispatched       = done_sel;
        res_next.out_channel      = sel_ch;
        res_next.out_frame_tag    = sel_tag;
        res_next.out_frame_time   = sel_time;
        res_next.out_submitted_at = sel_sub;
        res_next.wake_valid       = !done_sel && wv;
        res_next.wake_time        = (!done_sel && wv) ? wake : '0;
        res_next.stale_count      = drops;
      end
      default: begin
        fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fire;
    end
    if (fire) begin
      res <= res_next;
    end
  end

  assign status           = res.status;
  assign dispatched       = res.dispatched;
  assign out_channel      = res.out_channel;
  assign out_frame_tag    = res.out_frame_tag;
  assign out_frame_time   = res.out_frame_time;
  assign out_submitted_at = res.out_submitted_at;
  assign wake_valid       = res.wake_valid;
  assign wake_time        = res.wake_time;
  assign replaced         = res.replaced;
  assign throttled        = res.throttled;
  assign stale_count      = res.stale_count;
  assign deliver          = res.deliver;

  // Sequencer and per-slot flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      regd       <= '0;
      running    <= '0;
      full       <= '0;
      rr_pointer <= '0;
      accepting  <= 1'b0;
      done_sel   <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            slot_q  <= channel_slot;
            tag_q   <= frame_tag;
            ftime_q <= frame_time;
            now_q   <= now_time;
            case (command)
              CMD_REGISTER: begin
                if (div_go) state <= ST_DIV;
              end
              CMD_UNREGISTER: begin
                if (in_range && used[channel_slot]) begin
                  regd[channel_slot] <= 1'b0;
                  full[channel_slot] <= 1'b0;
                  if (!running[channel_slot]) used[channel_slot] <= 1'b0;
                end
              end
              CMD_SUBMIT: begin
                if (accepting && in_range && used[channel_slot] && regd[channel_slot]) begin
                  state <= ST_SUB;
                end
              end
              CMD_SELECT: begin
                if (accepting) begin
                  state    <= ST_SCAN;
                  ptr_q    <= rr_pointer;
                  ev_slot  <= rr_pointer;
                  scan_cnt <= 4'd1;
                  drops    <= '0;
                  wv       <= 1'b0;
                  wake     <= '1;
                  done_sel <= 1'b0;
                  sel_ch   <= '0;
                  sel_tag  <= '0;
                  sel_time <= '0;
                  sel_sub  <= '0;
                  age_en_q <= max_frame_age != '0 && now_time > TIME_W'(max_frame_age);
                  cutoff_q <= now_time - TIME_W'(max_frame_age);
                end
              end
              CMD_COMPLETE: begin
                if (in_range && used[channel_slot] && running[channel_slot]) begin
                  running[channel_slot] <= 1'b0;
                  if (!regd[channel_slot]) begin
                    used[channel_slot] <= 1'b0;
                    full[channel_slot] <= 1'b0;
                  end
                end
              end
              CMD_START: begin
                accepting <= 1'b1;
              end
              CMD_STOP: begin
                if (accepting) begin
                  accepting <= 1'b0;
                  full      <= '0;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            used[slot_q]    <= 1'b1;
            regd[slot_q]    <= 1'b1;
            running[slot_q] <= 1'b0;
            full[slot_q]    <= 1'b0;
            state           <= ST_IDLE;
          end
        end
        ST_SUB: begin
          full[slot_q] <= 1'b1;
          state        <= ST_IDLE;
        end
        ST_SCAN: begin
          // Stale frames are dropped first; the first ready slot is dispatched.
          if (stale_now) begin
            full[ev_slot] <= 1'b0;
            drops         <= drops + 1'b1;
          end
          if (disp_now) begin
            full[ev_slot]    <= 1'b0;
            running[ev_slot] <= 1'b1;
            rr_pointer       <= ev_slot + 1'b1;
            done_sel         <= 1'b1;
            sel_ch           <= ev_slot;
            sel_tag          <= rd_data.tag;
            sel_time         <= rd_data.ftime;
            sel_sub          <= rd_data.subm;
          end else if (cand_now) begin
            wv <= 1'b1;
            if (rd_data.elig < wake) wake <= rd_data.elig;
          end
          if (scan_cnt == 4'(NUM_CHANNELS)) begin
            state <= ST_FIN;
          end else begin
            ev_slot  <= ptr_q + scan_cnt[SLOT_W-1:0];
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_result_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) && !$past(busy)) || $past(busy))
    else $error("result without a transaction in progress");

  a_flag_hierarchy: assert property (@(posedge clk) disable iff (rst)
    ((regd & ~used) == '0) && ((running & ~used) == '0) && ((full & ~regd) == '0))
    else $error("slot flags inconsistent");

  a_dispatch_excludes_wake: assert property (@(posedge clk) disable iff (rst)
    done && dispatched |-> !wake_valid && status == STS_OK)
    else $error("dispatch reported with wake time");

  a_dispatch_marks_running: assert property (@(posedge clk) disable iff (rst)
    disp_now |=> running[$past(ev_slot)] && rr_pointer == $past(ev_slot) + 1'b1)
    else $error("dispatched slot not marked running");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rlmb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic [2:0]  status;
    logic        dispatched;
    logic [2:0]  channel;
    logic [31:0] tag;
    logic [31:0] ftime;
    logic [31:0] submitted;
    logic        wake_valid;
    logic [31:0] wake_time;
    logic        replaced;
    logic        throttled;
    logic [3:0]  stale;
    logic        deliver;
  } outcome_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [2:0] command;
  logic [SLOT_W-1:0] channel_slot;
  logic [FPS_W-1:0] target_fps;
  logic [31:0] frame_tag;
  logic [31:0] frame_time;
  logic [31:0] now_time;
  logic done;
  logic [2:0] status;
  logic dispatched;
  logic [SLOT_W-1:0] out_channel;
  logic [31:0] out_frame_tag;
  logic [31:0] out_frame_time;
  logic [31:0] out_submitted_at;
  logic wake_valid;
  logic [31:0] wake_time;
  logic replaced;
  logic throttled;
  logic [3:0] stale_count;
  logic deliver;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rate_limited_mailbox_round_robin uut (.*);

  // Predicted scheduler state.
  logic        ch_used [NUM_CHANNELS];
  logic        ch_reg [NUM_CHANNELS];
  logic        ch_run [NUM_CHANNELS];
  logic        box_full [NUM_CHANNELS];
  logic [31:0] box_tag [NUM_CHANNELS];
  logic [31:0] box_time [NUM_CHANNELS];
  logic [31:0] box_sub [NUM_CHANNELS];
  logic [31:0] ready_at [NUM_CHANNELS];
  logic [31:0] gap_ms [NUM_CHANNELS];
  int unsigned next_ch;
  logic        open_gate;
  logic [15:0] age_limit;

  outcome_t pending_q[$];
  int errors = 0;
  int unsigned cycles = 0;
  logic [31:0] clock_ms = 0;

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void wipe_channel(int s);
    ch_used[s] = 0;
    ch_reg[s] = 0;
    ch_run[s] = 0;
    box_full[s] = 0;
    box_tag[s] = 0;
    box_time[s] = 0;
    box_sub[s] = 0;
    ready_at[s] = 0;
    gap_ms[s] = 0;
  endfunction

  function automatic void reset_schedule();
    for (int s = 0; s < NUM_CHANNELS; s++) wipe_channel(s);
    next_ch = 0;
    open_gate = 0;
    age_limit = 0;
  endfunction

  // Works out the result of one command and advances the predicted state.
  function automatic outcome_t schedule_step(logic [2:0] cmd, int s, int unsigned fps,
                                             logic [31:0] tag, logic [31:0] ftime,
                                             logic [31:0] now);
    outcome_t r;
    int unsigned drops;
    int unsigned i;
    logic [31:0] wake;
    logic [31:0] cutoff;
    logic [32:0] sum;
    bit wv;
    bit found;
    r = '0;
    drops = 0;
    wv = 0;
    found = 0;
    wake = 32'hFFFF_FFFF;
    case (cmd)
      CMD_REGISTER: begin
        if (ch_used[s]) begin
          r.status = STS_DUPLICATE;
        end else begin
          wipe_channel(s);
          ch_used[s] = 1;
          ch_reg[s] = 1;
          gap_ms[s] = 1000 / (fps == 0 ? 1 : fps);
        end
      end
      CMD_UNREGISTER: begin
        if (!ch_used[s]) begin
          r.status = STS_UNKNOWN;
        end else begin
          ch_reg[s] = 0;
          box_full[s] = 0;
          if (!ch_run[s]) wipe_channel(s);
        end
      end
      CMD_SUBMIT: begin
        if (!open_gate) begin
          r.status = STS_NOT_ACC;
        end else if (!ch_used[s] || !ch_reg[s]) begin
          r.status = STS_UNKNOWN;
        end else begin
          r.replaced = box_full[s];
          r.throttled = ch_run[s] || (now < ready_at[s]);
          box_full[s] = 1;
          box_tag[s] = tag;
          box_time[s] = ftime;
          box_sub[s] = now;
        end
      end
      CMD_SELECT: begin
        if (!open_gate) begin
          r.status = STS_NOT_ACC;
        end else begin
          // Stale frames go first.
          if (age_limit != 0 && now > age_limit) begin
            cutoff = now - age_limit;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
              if (ch_used[k] && box_full[k] && box_time[k] > 0 && box_time[k] < cutoff) begin
                box_full[k] = 0;
                drops++;
              end
            end
          end
          r.stale = drops[3:0];
          // Round-robin scan from the pointer.
          for (int off = 0; off < NUM_CHANNELS && !found; off++) begin
            i = (next_ch + off) % NUM_CHANNELS;
            if (ch_used[i] && ch_reg[i] && box_full[i] && !ch_run[i]) begin
              if (now < ready_at[i]) begin
                if (ready_at[i] < wake) wake = ready_at[i];
                wv = 1;
              end else begin
                r.dispatched = 1;
                r.channel = i[2:0];
                r.tag = box_tag[i];
                r.ftime = box_time[i];
                r.submitted = box_sub[i];
                box_full[i] = 0;
                ch_run[i] = 1;
                sum = {1'b0, now} + {1'b0, gap_ms[i]};
                ready_at[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                next_ch = (i + 1) % NUM_CHANNELS;
                found = 1;
              end
            end
          end
          if (!found) begin
            r.status = STS_NONE;
            if (wv) begin
              r.wake_valid = 1;
              r.wake_time = wake;
            end
          end
        end
      end
      CMD_COMPLETE: begin
        if (!ch_used[s]) begin
          r.status = STS_UNKNOWN;
        end else if (ch_run[s]) begin
          ch_run[s] = 0;
          r.deliver = open_gate && ch_reg[s];
          if (!ch_reg[s]) wipe_channel(s);
        end
      end
      CMD_START: open_gate = 1;
      CMD_STOP: begin
        if (open_gate) begin
          open_gate = 0;
          for (int k = 0; k < NUM_CHANNELS; k++) box_full[k] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Prints one mismatch and counts it.
  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  // Result checker: every strobe is matched with the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $display("[%0t] result with no command outstanding", $realtime);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (status !== want.status) report("status", status, want.status);
        if (dispatched !== want.dispatched) report("dispatched", dispatched, want.dispatched);
        if (out_channel !== want.channel) report("out_channel", out_channel, want.channel);
        if (out_frame_tag !== want.tag) report("out_frame_tag", out_frame_tag, want.tag);
        if (out_frame_time !== want.ftime) report("out_frame_time", out_frame_time, want.ftime);
        if (out_submitted_at !== want.submitted)
          report("out_submitted_at", out_submitted_at, want.submitted);
        if (wake_valid !== want.wake_valid) report("wake_valid", wake_valid, want.wake_valid);
        if (wake_time !== want.wake_time) report("wake_time", wake_time, want.wake_time);
        if (replaced !== want.replaced) report("replaced", replaced, want.replaced);
        if (throttled !== want.throttled) report("throttled", throttled, want.throttled);
        if (stale_count !== want.stale) report("stale_count", stale_count, want.stale);
        if (deliver !== want.deliver) report("deliver", deliver, want.deliver);
      end
    end
  end

  // Sends one command transaction after a random pause; start stays high on return.
  task automatic issue(logic [2:0] cmd, int s, int unsigned fps, logic [31:0] tag,
                       logic [31:0] ftime, logic [31:0] now);
    int unsigned pause;
    outcome_t predicted;
    pause = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) pause = 0;
    if (pause > 0) begin
      start <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    channel_slot <= s[SLOT_W-1:0];
    target_fps <= fps[FPS_W-1:0];
    frame_tag <= tag;
    frame_time <= ftime;
    now_time <= now;
    do @(posedge clk); while (busy);
    predicted = schedule_step(cmd, s, fps, tag, ftime, now);
    pending_q = {pending_q, predicted};
  endtask

  // Drains outstanding results, then writes the age limit over the APB port.
  task automatic set_age_limit(logic [15:0] value);
    start <= 1'b0;
    @(posedge clk);
    wait (pending_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * REG_MAX_FRAME_AGE);
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    age_limit = value;
  endtask

  // Corner cases of every command.
  task automatic test_directed();
    issue(CMD_SUBMIT, 0, 0, 32'h1, 32'h1, 32'd10);
    issue(CMD_SELECT, 0, 0, 0, 0, 32'd10);
    issue(CMD_REGISTER, 0, 0, 0, 0, 0);
    issue(CMD_REGISTER, 1, 1000, 0, 0, 0);
    issue(CMD_REGISTER, 7, 1023, 0, 0, 0);
    issue(CMD_REGISTER, 1, 5, 0, 0, 0);
    issue(CMD_UNREGISTER, 4, 0, 0, 0, 0);
    issue(3'd7, 3, 512, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_START, 0, 0, 0, 0, 0);
    issue(CMD_START, 0, 0, 0, 0, 0);
    issue(CMD_SUBMIT, 5, 0, 32'hA, 32'd1, 32'd20);
    issue(CMD_SUBMIT, 0, 0, 32'hFFFF_FFFF, 32'd15, 32'd20);
    issue(CMD_SUBMIT, 0, 0, 32'h1234_5678, 32'd0, 32'd21);
    issue(CMD_SELECT, 0, 0, 0, 0, 32'd22);
    issue(CMD_SUBMIT, 0, 0, 32'h55, 32'd23, 32'd23);
    issue(CMD_SELECT, 0, 0, 0, 0, 32'd30);
    issue(CMD_COMPLETE, 0, 0, 0, 0, 0);
    issue(CMD_COMPLETE, 0, 0, 0, 0, 0);
    issue(CMD_COMPLETE, 6, 0, 0, 0, 0);
    issue(CMD_SUBMIT, 7, 0, 32'h77, 32'hFFFF_FFF0, 32'hFFFF_FFF0);
    issue(CMD_SELECT, 0, 0, 0, 0, 32'hFFFF_FFFF);
    issue(CMD_UNREGISTER, 7, 0, 0, 0, 0);
    issue(CMD_COMPLETE, 7, 0, 0, 0, 0);
    issue(CMD_STOP, 0, 0, 0, 0, 0);
    issue(CMD_STOP, 0, 0, 0, 0, 0);
  endtask

  // Stale dropping with the age limit at its extremes.
  task automatic test_stale();
    set_age_limit(16'd1);
    issue(CMD_START, 0, 0, 0, 0, 0);
    issue(CMD_REGISTER, 2, 1000, 0, 0, 0);
    issue(CMD_SUBMIT, 0, 0, 32'h10, 32'd100, 32'd100);
    issue(CMD_SUBMIT, 1, 0, 32'h11, 32'd0, 32'd100);
    issue(CMD_SUBMIT, 2, 0, 32'h12, 32'd99, 32'd100);
    issue(CMD_SELECT, 0, 0, 0, 0, 32'd102);
    issue(CMD_SELECT, 0, 0, 0, 0, 32'd5000);
    set_age_limit(16'hFFFF);
    issue(CMD_SUBMIT, 2, 0, 32'h13, 32'd1, 32'd70000);
    issue(CMD_SELECT, 0, 0, 0, 0, 32'd65537);
    issue(CMD_SELECT, 0, 0, 0, 0, 32'd65538);
  endtask

  // Mostly well-formed traffic with a rising clock and random content.
  task automatic test_random(int count);
    int unsigned pick;
    int s;
    int unsigned fps;
    logic [31:0] ft;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      s = $urandom_range(0, NUM_CHANNELS - 1);
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, 25);
      case ($urandom_range(0, 9))
        0: ft = 0;
        1: ft = $urandom();
        default: ft = clock_ms - $urandom_range(0, 120);
      endcase
      fps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(20, 1000);
      if (pick < 10) begin
        issue(CMD_REGISTER, s, fps, 0, 0, 0);
      end else if (pick < 15) begin
        issue(CMD_UNREGISTER, s, 0, 0, 0, 0);
      end else if (pick < 50) begin
        issue(CMD_SUBMIT, s, 0, $urandom(), ft, clock_ms);
      end else if (pick < 80) begin
        issue(CMD_SELECT, 0, 0, 0, 0, clock_ms);
      end else if (pick < 94) begin
        // Prefer a channel that is running.
        for (int k = 0; k < NUM_CHANNELS; k++)
          if (ch_run[(s + k) % NUM_CHANNELS] && $urandom_range(0, 3) != 0) begin
            s = (s + k) % NUM_CHANNELS;
            break;
          end
        issue(CMD_COMPLETE, s, 0, 0, 0, 0);
      end else if (pick < 98) begin
        issue(open_gate ? CMD_START : CMD_START, 0, 0, 0, 0, 0);
      end else if (pick < 99) begin
        issue(CMD_STOP, 0, 0, 0, 0, 0);
      end else begin
        issue(3'd7, s, fps, $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = CMD_START;
    channel_slot = '0;
    target_fps = '0;
    frame_tag = '0;
    frame_time = '0;
    now_time = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reset_schedule();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_stale();
    set_age_limit(16'd0);
    test_random(475);
    set_age_limit(16'd60);
    test_random(475);
    set_age_limit(16'hFFFF);
    test_random(475);
    set_age_limit(16'd1);
    test_random(475);

    start <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rlmb_pkg.sv
rtl/rlmb_div.sv
rtl/rate_limited_mailbox_round_robin.sv
tb/tb_top.sv
